### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_CLK is checked outside reset only; ASSERT_ALWAYS is checked on every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### hw/rtl/erma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package erma_pkg;

    localparam int SPEED_W   = 24;
    localparam int DT_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W   = 32;
    localparam int NUM_W     = 56;
    localparam int DEN_W     = 32;
    localparam int QUOT_W    = 24;
    localparam int STEP_W    = 5;

    // 60000 ms per minute times 256 for Q16.8
    localparam logic [31:0] RPM_SCALE = 32'd15360000;
    localparam logic [SPEED_W-1:0] PRIME_THRESH = 24'd128;

    localparam logic [CFG_W-1:0] EPR_RESET  = 16'd20;
    localparam logic [CFG_W-1:0] GEAR_RESET = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_REV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO    = 1'b1;

    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_SERVICE = 1'b1;

    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/erma_div.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle. Quotients that do not fit
// in QUOT_W bits (including a zero divisor) saturate without stepping.
module erma_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [erma_pkg::NUM_W-1:0]     num,
    input  wire logic [erma_pkg::DEN_W-1:0]     den,
    output logic      [erma_pkg::QUOT_W-1:0]    quot,
    output erma_pkg::div_stat_t                 stat
);

    localparam int QW = erma_pkg::QUOT_W;
    localparam int DW = erma_pkg::DEN_W;

    logic [DW-1:0]                  rem_reg;
    logic [QW-1:0]                  low_reg;
    logic [DW-1:0]                  den_reg;
    logic [erma_pkg::STEP_W-1:0]    step_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic                           sat_reg;

    logic [DW:0]                    trial;
    logic                           ge;
    logic [DW:0]                    diff;
    logic [DW-1:0]                  rem_next;
    logic                           ovf;

    always_comb
    begin
        trial    = {rem_reg, low_reg[QW-1]};
        ge       = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        ovf      = num[erma_pkg::NUM_W-1:QW] >= den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                step_reg <= '0;
                busy_reg <= !ovf;
                done_reg <= ovf;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + erma_pkg::STEP_W'(1);
                busy_reg <= step_reg != erma_pkg::STEP_W'(QW - 1);
                done_reg <= step_reg == erma_pkg::STEP_W'(QW - 1);
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[erma_pkg::NUM_W-1:QW];
            low_reg <= ovf ? '1 : num[QW-1:0];
            den_reg <= den;
            sat_reg <= ovf;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QW-2:0], ge};
        end
    end

    assign quot      = low_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

    `ASSERT_CLK(a_no_restart, clk, rst_n, start |-> !busy_reg)
    `ASSERT_CLK(a_ovf_fast, clk, rst_n, start && ovf |=> done_reg && sat_reg && low_reg == '1)
    `ASSERT_CLK(a_done_pulse, clk, rst_n, done_reg |=> !done_reg)

endmodule

`default_nettype wire

### hw/rtl/erma_ring.sv
`timescale 1ns / 1ps
`default_nettype none

// Speed history. Entries never written read as zero.
module erma_ring
#(
    parameter int RING_DEPTH = 10,
    parameter int POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [POS_W-1:0]               wr_addr,
    input  wire logic [erma_pkg::SPEED_W-1:0]   wr_data,
    input  wire logic                           rd_en,
    input  wire logic [POS_W-1:0]               rd_addr,
    output logic      [erma_pkg::SPEED_W-1:0]   rd_data
);

    logic [erma_pkg::SPEED_W-1:0]   mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]          valid_reg;
    logic [erma_pkg::SPEED_W-1:0]   data_reg;
    logic                           hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

### hw/rtl/encoder_rpm_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Quadrature encoder speed meter with a moving average. An edge item
// (command 0) steps a signed 32-bit tick count by -1 when enc_b differs from
// enc_a and +1 otherwise, and gives no result. A service item (command 1)
// takes and clears the tick count, forms the speed as |ticks| * 60000 *
// 256 / (edges_per_rev * dt_ms) in unsigned Q16.8, stores it in a ring of
// RING_DEPTH samples and returns the ring average divided by the Q8.8 gear
// ratio. Both quotients go through one shared restoring divider at one bit
// per cycle, one after the other. The first speed above 0.5 rpm is written
// into every slot, so the whole ring is filled with it, and a finished
// result waits for the previous one to leave the output register. A
// quotient that would not fit 24 bits, or a zero divisor, skips the
// division steps, comes out as 0xFFFFFF and sets saturated. in_stall is
// high for the whole of a service item; one finished item may wait in the
// output register while new edge items are taken. Configuration
// (edges_per_rev at index 0, gear_ratio_q8 at index 1) is always ready;
// the user must write it only while idle; the block does not enforce it.
module encoder_rpm_moving_average
#(
    parameter int RING_DEPTH = 10
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic                               enc_a,
    input  wire logic                               enc_b,
    input  wire logic [erma_pkg::DT_W-1:0]          dt_ms,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [erma_pkg::SPEED_W-1:0]       rpm_avg,
    output logic                                    saturated,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [erma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [erma_pkg::CFG_W-1:0]         cfg_data
);

    localparam int POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    // ring sum never exceeds RING_DEPTH full-scale speeds
    localparam int SUM_W = erma_pkg::SPEED_W + POS_W;
    localparam int SW    = erma_pkg::SPEED_W;
    localparam int CW    = erma_pkg::COUNT_W;
    localparam int NW    = erma_pkg::NUM_W;
    localparam int DW    = erma_pkg::DEN_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_DIV1  = 9'b000000100,
        S_RD    = 9'b000001000,
        S_FILL  = 9'b000010000,
        S_UPD   = 9'b000100000,
        S_PREP2 = 9'b001000000,
        S_DIV2  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;

    // control state
    logic [CW-1:0]                  edge_count_reg;
    logic [POS_W-1:0]               pos_reg;
    logic [POS_W-1:0]               fill_idx_reg;
    logic                           primed_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic                           div_start_reg;
    logic                           out_valid_reg;
    logic [erma_pkg::CFG_W-1:0]     epr_reg;
    logic [erma_pkg::CFG_W-1:0]     gear_reg;

    // payload
    logic [CW-1:0]                  mag_reg;
    logic [erma_pkg::DT_W-1:0]      dt_reg;
    logic [NW-1:0]                  num_reg;
    logic [DW-1:0]                  den_reg;
    logic [SW-1:0]                  speed_reg;
    logic [SW-1:0]                  res_reg;
    logic                           sat_reg;
    logic [SW-1:0]                  rpm_avg_reg;
    logic                           saturated_reg;

    logic                           in_accept;
    logic                           svc_accept;
    logic                           out_load;
    logic                           prime_hit;
    logic                           fill_last;
    logic [POS_W-1:0]               pos_adv;
    logic [CW-1:0]                  count_abs;
    logic [CW-1:0]                  count_step;

    logic [erma_pkg::QUOT_W-1:0]    div_quot;
    erma_pkg::div_stat_t            div_stat;

    logic                           ring_wr_en;
    logic [POS_W-1:0]               ring_wr_addr;
    logic                           ring_rd_en;
    logic [SW-1:0]                  ring_old;

    always_comb
    begin
        in_accept  = in_valid && !in_stall;
        svc_accept = in_accept && command == erma_pkg::CMD_SERVICE;
        out_load   = !out_valid_reg || !out_stall;
        prime_hit  = !primed_reg && (speed_reg > erma_pkg::PRIME_THRESH);
        fill_last  = fill_idx_reg == POS_W'(RING_DEPTH - 1);
        pos_adv    = (pos_reg == POS_W'(RING_DEPTH - 1)) ? '0 : pos_reg + POS_W'(1);
        // magnitude of the most negative count is 2^31, which still fits
        count_abs  = edge_count_reg[CW-1] ? (~edge_count_reg + CW'(1)) : edge_count_reg;
        count_step = (enc_a != enc_b) ? {CW{1'b1}} : CW'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (svc_accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_stat.done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = prime_hit ? S_FILL : S_UPD;
            end
            S_FILL:
            begin
                if (fill_last)
                begin
                    state_next = S_PREP2;
                end
            end
            S_UPD:
            begin
                state_next = S_PREP2;
            end
            S_PREP2:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_count_reg <= '0;
            pos_reg        <= '0;
            fill_idx_reg   <= '0;
            primed_reg     <= 1'b0;
            sum_reg        <= '0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            epr_reg        <= erma_pkg::EPR_RESET;
            gear_reg       <= erma_pkg::GEAR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            // divider start is registered from S_MUL or S_PREP2, so it rises with the operands loaded there
            div_start_reg <= (state_reg == S_MUL) || (state_reg == S_PREP2);

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    erma_pkg::CFG_EDGES_PER_REV: epr_reg  <= cfg_data;
                    erma_pkg::CFG_GEAR_RATIO:    gear_reg <= cfg_data;
                endcase
            end

            if (state_reg == S_OUT && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (command == erma_pkg::CMD_EDGE)
                        begin
                            edge_count_reg <= edge_count_reg + count_step;
                        end
                        else
                        begin
                            edge_count_reg <= '0;
                        end
                    end
                end
                S_FILL:
                begin
                    // first real speed: every slot holds it, sum follows
                    fill_idx_reg <= fill_last ? '0 : fill_idx_reg + POS_W'(1);
                    if (fill_last)
                    begin
                        sum_reg    <= SUM_W'(speed_reg) * SUM_W'(RING_DEPTH);
                        primed_reg <= 1'b1;
                        pos_reg    <= pos_adv;
                    end
                end
                S_UPD:
                begin
                    // running sum: drop the overwritten sample, add the new one
                    sum_reg <= sum_reg - SUM_W'(ring_old) + SUM_W'(speed_reg);
                    pos_reg <= pos_adv;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (svc_accept)
                begin
                    mag_reg <= count_abs;
                    dt_reg  <= dt_ms;
                end
            end
            S_MUL:
            begin
                num_reg <= NW'(mag_reg) * NW'(erma_pkg::RPM_SCALE);
                den_reg <= DW'(epr_reg) * DW'(dt_reg);
                sat_reg <= 1'b0;
            end
            S_DIV1:
            begin
                if (div_stat.done)
                begin
                    speed_reg <= div_quot;
                    sat_reg   <= div_stat.sat;
                end
            end
            S_PREP2:
            begin
                // average and gear ratio as one quotient: sum * 256 / (depth * gear)
                num_reg <= NW'({sum_reg, 8'h00});
                den_reg <= DW'(gear_reg) * DW'(RING_DEPTH);
            end
            S_DIV2:
            begin
                if (div_stat.done)
                begin
                    res_reg <= div_quot;
                    sat_reg <= sat_reg | div_stat.sat;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    rpm_avg_reg   <= res_reg;
                    saturated_reg <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ring_wr_en   = (state_reg == S_FILL) || (state_reg == S_UPD);
        ring_wr_addr = (state_reg == S_FILL) ? fill_idx_reg : pos_reg;
        ring_rd_en   = state_reg == S_RD;
    end

    erma_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_reg),
        .den   (den_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    erma_ring
    #(
        .RING_DEPTH (RING_DEPTH),
        .POS_W      (POS_W)
    )
    u_ring
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (speed_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ring_old)
    );

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign rpm_avg   = rpm_avg_reg;
    assign saturated = saturated_reg;
    assign cfg_ready = 1'b1;

    `ASSERT_ALWAYS(a_pos_range, clk, pos_reg <= POS_W'(RING_DEPTH - 1))
    `ASSERT_CLK(a_count_clear, clk, rst_n, svc_accept |=> edge_count_reg == '0)
    `ASSERT_CLK(a_div_owner, clk, rst_n, div_stat.done |-> state_reg == S_DIV1 || state_reg == S_DIV2)
    `ASSERT_CLK(a_primed_sticky, clk, rst_n, primed_reg |=> primed_reg)

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

// Encoder speed meter with moving average.
//
// A directed table opens the run: every edge direction, the priming
// threshold, zero dt, clipped speed and output, zero divisors, and the dt
// extremes. Then randomised phases follow, each with its own register
// setting. Every service item is predicted by the speed model below and its
// result checked in order against what the block returns.
module tb;

    localparam int RING          = 10;
    localparam int HALF_PERIOD   = 4;
    localparam int MAX_GAP       = 19;
    // margin for a service item's input stall, including the ring fill on priming
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 70;
    localparam int RAND_ITEMS    = 350;
    localparam int MAX_REPORT    = 10;
    localparam int CYCLE_LIMIT   = 500000;

    localparam int SPEED_W   = erma_pkg::SPEED_W;
    localparam int DT_W      = erma_pkg::DT_W;
    localparam int CFG_W     = erma_pkg::CFG_W;
    localparam int CFG_IDX_W = erma_pkg::CFG_IDX_W;
    localparam int COUNT_W   = erma_pkg::COUNT_W;

    // 60000 ms per minute, scaled by 256 for Q16.8
    localparam logic [63:0] TICK_SCALE = 64'd15_360_000;
    localparam logic [SPEED_W-1:0] SPEED_TOP = '1;
    localparam logic [SPEED_W-1:0] PRIME_LEVEL = 24'd128;

    typedef struct packed {
        logic [SPEED_W-1:0] rpm;
        logic               sat;
    } speed_result_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 cmd;
        logic                 a;
        logic                 b;
        logic [DT_W-1:0]      dt;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic                 typed;
        speed_result_t        res;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 command;
    logic                 enc_a;
    logic                 enc_b;
    logic [DT_W-1:0]      dt_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic [SPEED_W-1:0]   rpm_avg;
    logic                 saturated;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Speed model state, after reset.
    logic [COUNT_W-1:0] tick_count = '0;
    logic [SPEED_W-1:0] speed_hist [RING] = '{default: '0};
    int unsigned        hist_pos = 0;
    bit                 hist_primed = 1'b0;
    logic [CFG_W-1:0]   epr_cfg = erma_pkg::EPR_RESET;
    logic [CFG_W-1:0]   gear_cfg = erma_pkg::GEAR_RESET;

    speed_result_t pending_speeds [$];
    plan_row_t     plan [$];
    int            error_count = 0;
    int            speeds_issued = 0;
    int            cycle_count = 0;
    bit            quiet = 1'b0;      // no idling on either side
    bit            long_hold = 1'b0;  // receiver holds off once, long enough for the output to fill

    encoder_rpm_moving_average #(
        .RING_DEPTH (RING)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .enc_a     (enc_a),
        .enc_b     (enc_b),
        .dt_ms     (dt_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rpm_avg   (rpm_avg),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Advances the speed model by one item. Returns 1 when the item gives a
    // result, with the expected fields in res.
    function automatic bit predict_speed(input logic cmd, input logic a, input logic b,
                                         input logic [DT_W-1:0] dt,
                                         output speed_result_t res);
        logic [COUNT_W-1:0] mag;
        logic [63:0]        den;
        logic [63:0]        quot;
        logic [63:0]        sum;
        logic [SPEED_W-1:0] spd;
        res = '0;
        if (cmd == erma_pkg::CMD_EDGE)
        begin
            // B differing from A counts down
            tick_count = tick_count + ((a != b) ? 32'hFFFF_FFFF : 32'd1);
            return 1'b0;
        end
        // the most negative count has magnitude 2^31, which still fits
        mag = tick_count[COUNT_W-1] ? (32'd0 - tick_count) : tick_count;
        tick_count = '0;
        den = 64'(epr_cfg) * 64'(dt);
        if (den == 64'd0)
        begin
            spd = SPEED_TOP;
            res.sat = 1'b1;
        end
        else
        begin
            quot = (64'(mag) * TICK_SCALE) / den;
            if (quot > 64'(SPEED_TOP))
            begin
                spd = SPEED_TOP;
                res.sat = 1'b1;
            end
            else
                spd = quot[SPEED_W-1:0];
        end
        // first real speed fills the whole ring
        if (!hist_primed && spd > PRIME_LEVEL)
        begin
            for (int i = 0; i < RING; i++)
                speed_hist[i] = spd;
            hist_primed = 1'b1;
        end
        speed_hist[hist_pos] = spd;
        hist_pos = (hist_pos + 1) % RING;
        sum = '0;
        for (int i = 0; i < RING; i++)
            sum = sum + 64'(speed_hist[i]);
        // average and gear division as one truncating quotient
        den = 64'(RING) * 64'(gear_cfg);
        if (den == 64'd0)
        begin
            res.rpm = SPEED_TOP;
            res.sat = 1'b1;
        end
        else
        begin
            quot = (sum * 64'd256) / den;
            if (quot > 64'(SPEED_TOP))
            begin
                res.rpm = SPEED_TOP;
                res.sat = 1'b1;
            end
            else
                res.rpm = quot[SPEED_W-1:0];
        end
        return 1'b1;
    endfunction

    function automatic plan_row_t edge_row(input logic a, input logic b);
        plan_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd = erma_pkg::CMD_EDGE;
        r.a = a;
        r.b = b;
        return r;
    endfunction

    function automatic plan_row_t svc_row(input logic [DT_W-1:0] dt);
        plan_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd = erma_pkg::CMD_SERVICE;
        r.dt = dt;
        return r;
    endfunction

    // service row whose result is known outright
    function automatic plan_row_t svc_known(input logic [DT_W-1:0] dt,
                                            input logic [SPEED_W-1:0] rpm,
                                            input logic sat);
        plan_row_t r;
        r = svc_row(dt);
        r.typed = 1'b1;
        r.res.rpm = rpm;
        r.res.sat = sat;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // dt for a service item: mostly short intervals, now and then the extremes
    function automatic logic [DT_W-1:0] draw_dt();
        unique case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2, 3: return DT_W'($urandom);
            default: return DT_W'($urandom_range(1, 120));
        endcase
    endfunction

    // Offers one item after a random gap and waits until it is taken. The
    // expectation is pushed at the edge that takes the item; a typed row
    // replaces the predicted result but the model still advances.
    task automatic send_item(input logic cmd, input logic a, input logic b,
                             input logic [DT_W-1:0] dt, input bit typed,
                             input speed_result_t typed_res);
        int            gap;
        speed_result_t res;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        enc_a    <= a;
        enc_b    <= b;
        dt_ms    <= dt;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        if (predict_speed(cmd, a, b, dt, res))
        begin
            pending_speeds.push_back(typed ? typed_res : res);
            speeds_issued++;
        end
    endtask

    // Sender pauses until every result is back, then lets the block finish
    // any edge item still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        unique case (idx)
            erma_pkg::CFG_EDGES_PER_REV: epr_cfg = val;
            erma_pkg::CFG_GEAR_RATIO:    gear_cfg = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random phase: mostly bursts of edges turning one way, now and
    // then a slipped edge, closed by a service item; the rest is loose items.
    task automatic run_phase(input int n_items);
        int   sent;
        int   burst;
        bit   down;
        logic a;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                          logic'($urandom_range(0, 1)), draw_dt(), 1'b0, '0);
                sent++;
            end
            else
            begin
                burst = int'($urandom_range(0, 16));
                down = 1'($urandom_range(0, 1));
                repeat (burst)
                begin
                    a = 1'($urandom_range(0, 1));
                    send_item(erma_pkg::CMD_EDGE, a,
                              (down ^ ($urandom_range(0, 15) == 0)) ? ~a : a,
                              DT_W'($urandom), 1'b0, '0);
                    sent++;
                end
                send_item(erma_pkg::CMD_SERVICE, logic'($urandom_range(0, 1)),
                          logic'($urandom_range(0, 1)), draw_dt(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Result checker: every item leaving the block must match the oldest
    // expectation.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_speeds.size() == 0)
            begin
                if (error_count < MAX_REPORT)
                    $display("unexpected result: rpm_avg %h saturated %b", rpm_avg, saturated);
                error_count++;
            end
            else
            begin
                speed_result_t want;
                want = pending_speeds.pop_front();
                if (rpm_avg !== want.rpm || saturated !== want.sat)
                begin
                    if (error_count < MAX_REPORT)
                        $display("mismatch: rpm_avg %h exp %h, saturated %b exp %b",
                                 rpm_avg, want.rpm, saturated, want.sat);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver: a fresh hold per result, or a long hold-off on request so
    // that the output fills and the block stalls its input.
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid === 1'b1 && out_stall == 1'b0) && !long_hold)
                @(posedge clk);
        end
    end

    // Stimulus.
    initial
    begin
        int p;
        int rand_base;
        logic [CFG_W-1:0] epr_val;
        logic [CFG_W-1:0] gear_val;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= erma_pkg::CMD_EDGE;
        enc_a     <= 1'b0;
        enc_b     <= 1'b0;
        dt_ms     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= erma_pkg::CFG_EDGES_PER_REV;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first service after reset reads zero with an
        // empty ring; an edge of each kind follows, and these cancel out.
        plan = '{
            svc_known(16'd5, 24'd0, 1'b0),
            edge_row(1'b0, 1'b0), edge_row(1'b1, 1'b1),
            edge_row(1'b0, 1'b1), edge_row(1'b1, 1'b0),
            edge_row(1'b1, 1'b1),
            svc_row(16'd6000),                          // exactly 0.5 rpm: no priming
            edge_row(1'b1, 1'b0), edge_row(1'b0, 1'b1),
            svc_row(16'd1),                             // negative ticks, primes the ring
            svc_row(16'd0),                             // zero dt saturates
            edge_row(1'b0, 1'b0),
            svc_row(16'd7),                             // truncated quotient
            reg_row(erma_pkg::CFG_EDGES_PER_REV, 16'd1),
            edge_row(1'b0, 1'b0), edge_row(1'b1, 1'b1),
            svc_row(16'd1),                             // speed clipped
            reg_row(erma_pkg::CFG_GEAR_RATIO, 16'd1),
            edge_row(1'b0, 1'b0),
            svc_row(16'hFFFF),                          // output clipped
            reg_row(erma_pkg::CFG_GEAR_RATIO, 16'd0),
            svc_known(16'd9, SPEED_TOP, 1'b1),          // zero gear ratio
            reg_row(erma_pkg::CFG_EDGES_PER_REV, 16'hFFFF),
            reg_row(erma_pkg::CFG_GEAR_RATIO, 16'hFFFF),
            edge_row(1'b1, 1'b1),
            svc_row(16'd2),
            reg_row(erma_pkg::CFG_EDGES_PER_REV, 16'd0),
            svc_row(16'hFFFF)                           // zero edges per rev
        };
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_item(plan[i].cmd, plan[i].a, plan[i].b, plan[i].dt,
                          plan[i].typed, plan[i].res);
        end

        // Random phases, each with its own register setting.
        rand_base = 0;
        p = 0;
        while (rand_base < RAND_ITEMS)
        begin
            unique case (p)
                0: begin epr_val = erma_pkg::EPR_RESET; gear_val = erma_pkg::GEAR_RESET; end
                1: begin epr_val = 16'd1;     gear_val = 16'hFFFF;   end
                2: begin epr_val = 16'hFFFF;  gear_val = 16'd1;      end
                3: begin epr_val = 16'd4;     gear_val = 16'd128;    end
                default:
                begin
                    epr_val = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 65535))
                                                          : CFG_W'($urandom_range(1, 400));
                    gear_val = CFG_W'($urandom_range(16, 2048));
                end
            endcase
            wait_idle();
            write_reg(erma_pkg::CFG_EDGES_PER_REV, epr_val);
            write_reg(erma_pkg::CFG_GEAR_RATIO, gear_val);
            // phase 1 backs the output up; phase 3 runs flat out
            if (p == 1)
                long_hold = 1'b1;
            quiet = (p == 3);
            run_phase(PHASE_ITEMS);
            quiet = 1'b0;
            rand_base += PHASE_ITEMS;
            p++;
        end

        wait_idle();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
